// ----- hw/rtl/tlb_page_table_translator_unit_macros.svh -----
// ------------------------------------------------------------------------
// tlb page table translator assertion macros
// implication and next-cycle checks, empty when synthesized
// ------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_UNIT_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TLBPTU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlbptu assertion failed");
// next-cycle implication
`define TLBPTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlbptu assertion failed");
`else
`define TLBPTU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TLBPTU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/tlbptu_pkg.sv -----
// ------------------------------------------------------------------------
// tlbptu package
// address split, frame widths, lookup structs and control states
// ------------------------------------------------------------------------
package tlbptu_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int OFFSET_BITS = 8;
    localparam int PAGE_BITS   = ADDR_BITS - OFFSET_BITS;
    localparam int PAGE_COUNT  = 1 << PAGE_BITS;
    localparam int FRAME_BITS  = ADDR_BITS - OFFSET_BITS;
    // free frame counter must be able to hold PAGE_COUNT itself
    localparam int FREE_BITS   = PAGE_BITS + 1;
    localparam int COUNT_BITS  = 32;

    typedef logic [ADDR_BITS-1:0]   t_addr;
    typedef logic [OFFSET_BITS-1:0] t_offset;
    typedef logic [PAGE_BITS-1:0]   t_page;
    typedef logic [FRAME_BITS-1:0]  t_frame;
    typedef logic [FREE_BITS-1:0]   t_free;
    typedef logic [COUNT_BITS-1:0]  t_count;

    typedef struct packed {
        logic   valid;
        t_page  tag;
        t_frame frame;
    } t_tlb_entry;

    typedef struct packed {
        logic   hit;
        t_frame frame;
    } t_tlb_lookup;

    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_pm_read;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

// ----- hw/rtl/tlbptu_if.sv -----
// ------------------------------------------------------------------------
// tlbptu channel interfaces
// valid/ready channels for address items and translation items
// ------------------------------------------------------------------------
interface tlbptu_req_if;
    import tlbptu_pkg::*;

    logic  valid;
    logic  ready;
    t_addr virt_addr;

    modport source (output valid, output virt_addr, input ready);
    modport sink (input valid, input virt_addr, output ready);
endinterface

interface tlbptu_rsp_if;
    import tlbptu_pkg::*;

    logic   valid;
    logic   ready;
    t_addr  physical_address;
    logic   tlb_hit;
    logic   page_fault;
    t_count hit_total;
    t_count fault_total;
    t_count translated_total;

    modport source (
        output valid, output physical_address, output tlb_hit, output page_fault,
        output hit_total, output fault_total, output translated_total,
        input ready
    );
    modport sink (
        input valid, input physical_address, input tlb_hit, input page_fault,
        input hit_total, input fault_total, input translated_total,
        output ready
    );
endinterface

// ----- hw/rtl/tlbptu_cell.sv -----
// ------------------------------------------------------------------------
// tlbptu cell
// one tlb entry: compares its tag, shifts in its neighbor on insert
// ------------------------------------------------------------------------
module tlbptu_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  tlbptu_pkg::t_page      i_key,
    input  tlbptu_pkg::t_tlb_entry i_prev,
    output tlbptu_pkg::t_tlb_entry o_entry,
    output logic                   o_match
);
    import tlbptu_pkg::*;

    logic   r_valid;
    t_page  r_tag;
    t_frame r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tag   <= i_prev.tag;
            r_frame <= i_prev.frame;
        end
    end

    assign o_entry = '{valid: r_valid, tag: r_tag, frame: r_frame};
    assign o_match = r_valid && (r_tag == i_key);
endmodule

// ----- hw/rtl/tlbptu_tlb.sv -----
// ------------------------------------------------------------------------
// tlbptu tlb row
// chain of cells, newest entry enters at the head, oldest drops off
// ------------------------------------------------------------------------
module tlbptu_tlb #(
    parameter int TLB_ENTRIES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_insert,
    input  tlbptu_pkg::t_tlb_entry  i_new,
    input  tlbptu_pkg::t_page       i_key,
    output tlbptu_pkg::t_tlb_lookup o_lookup
);
    import tlbptu_pkg::*;

    t_tlb_entry             w_entry [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] w_match;

    for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
        t_tlb_entry w_prev;
        if (g == 0) begin : g_head
            assign w_prev = i_new;
        end else begin : g_body
            assign w_prev = w_entry[g-1];
        end
        tlbptu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_insert),
            .i_key   (i_key),
            .i_prev  (w_prev),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // a page sits in at most one cell, so at most one match bit is set
    always_comb begin
        o_lookup = '0;
        for (int k = 0; k < TLB_ENTRIES; k++) begin
            o_lookup.hit   = o_lookup.hit | w_match[k];
            o_lookup.frame = o_lookup.frame | (w_match[k] ? w_entry[k].frame : '0);
        end
    end
endmodule

// ----- hw/rtl/tlbptu_page_map.sv -----
// ------------------------------------------------------------------------
// tlbptu page map
// page to frame memory with valid flops and in-order frame allocation
// ------------------------------------------------------------------------
module tlbptu_page_map (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  tlbptu_pkg::t_page    i_rd_page,
    output tlbptu_pkg::t_pm_read o_rd,
    input  logic                 i_alloc,
    input  tlbptu_pkg::t_page    i_wr_page,
    output tlbptu_pkg::t_free    o_free_frame
);
    import tlbptu_pkg::*;

    t_frame                r_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_valid;
    logic                  r_rd_valid;
    t_frame                r_rd_frame;
    t_free                 r_free;
    t_free                 n_free;

    assign n_free = r_free + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_free     <= '0;
        end else begin
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_page];
            end
            if (i_alloc) begin
                r_valid[i_wr_page] <= 1'b1;
                r_free             <= n_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_frame <= r_mem[i_rd_page];
        end
        if (i_alloc) begin
            r_mem[i_wr_page] <= r_free[FRAME_BITS-1:0];
        end
    end

    assign o_rd         = '{valid: r_rd_valid, frame: r_rd_frame};
    assign o_free_frame = r_free;
endmodule

// ----- hw/rtl/tlb_page_table_translator_unit.sv -----
// ------------------------------------------------------------------------
// tlb page table translator unit
// address translation through a fifo tlb with demand paging
// ------------------------------------------------------------------------
//
// channel   dir  payload
// i_req     in   virt_addr (page in 15:8, offset in 7:0)
// o_rsp     out  physical_address, tlb_hit, page_fault, three running totals
//
// per item, the accept cycle reads the page map memory, the
// lookup cycle matches the tlb cells, resolves the frame and writes back
// no clearing pass after reset, page map and tlb valid bits are flops
// a result waits in the output register while the next item is accepted;
// that item's lookup cycle holds until the output register is free
// ------------------------------------------------------------------------
`include "tlb_page_table_translator_unit_macros.svh"

module tlb_page_table_translator_unit #(
    parameter int TLB_ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tlbptu_req_if.sink           i_req,
    tlbptu_rsp_if.source         o_rsp
);
    import tlbptu_pkg::*;

    // control
    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_fire;

    // item held between accept and lookup
    t_page   r_page;
    t_offset r_off;

    // lookup results
    t_tlb_lookup w_lookup;
    t_pm_read    w_pm;
    t_free       w_free_frame;
    logic        w_fault;
    t_frame      w_frame;
    t_tlb_entry  w_new;

    // running counts, also the totals of the result item
    t_count r_hit_cnt;
    t_count r_fault_cnt;
    t_count r_addr_cnt;

    // output register
    logic  r_out_valid;
    t_addr r_phys;
    logic  r_hit;
    logic  r_fault;

    assign w_accept = i_req.valid && i_req.ready;

    // ready and lookup completion
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        w_fire      = (r_state == ST_LOOKUP) && (!r_out_valid || o_rsp.ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // tlb row: searched with the held page, new entry shifted in on a miss
    tlbptu_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_tlb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_insert (w_fire && !w_lookup.hit),
        .i_new    (w_new),
        .i_key    (r_page),
        .o_lookup (w_lookup)
    );

    // page map: read on accept, written on a fault
    tlbptu_page_map u_page_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (w_accept),
        .i_rd_page    (i_req.virt_addr[ADDR_BITS-1:OFFSET_BITS]),
        .o_rd         (w_pm),
        .i_alloc      (w_fire && w_fault),
        .i_wr_page    (r_page),
        .o_free_frame (w_free_frame)
    );

    // frame choice: tlb hit, then mapped page, then a freshly allocated frame
    always_comb begin
        w_fault = !w_lookup.hit && !w_pm.valid;
        if (w_lookup.hit) begin
            w_frame = w_lookup.frame;
        end else if (w_pm.valid) begin
            w_frame = w_pm.frame;
        end else begin
            w_frame = w_free_frame[FRAME_BITS-1:0];
        end
        w_new = '{valid: 1'b1, tag: r_page, frame: w_frame};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            r_addr_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_addr_cnt  <= r_addr_cnt + 1'b1;
                if (w_lookup.hit) begin
                    r_hit_cnt <= r_hit_cnt + 1'b1;
                end
                if (w_fault) begin
                    r_fault_cnt <= r_fault_cnt + 1'b1;
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= i_req.virt_addr[ADDR_BITS-1:OFFSET_BITS];
            r_off  <= i_req.virt_addr[OFFSET_BITS-1:0];
        end
        if (w_fire) begin
            r_phys  <= {w_frame, r_off};
            r_hit   <= w_lookup.hit;
            r_fault <= w_fault;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.physical_address = r_phys;
    assign o_rsp.tlb_hit          = r_hit;
    assign o_rsp.page_fault       = r_fault;
    assign o_rsp.hit_total        = r_hit_cnt;
    assign o_rsp.fault_total      = r_fault_cnt;
    assign o_rsp.translated_total = r_addr_cnt;

    // a hit never faults
    `TLBPTU_ASSERT_IMPLY(a_hit_no_fault, i_clk, i_rst_n, o_rsp.valid, !(r_hit && r_fault))
    // an accepted item always goes to the lookup cycle
    `TLBPTU_ASSERT_NEXT(a_accept_lookup, i_clk, i_rst_n, w_accept, r_state == ST_LOOKUP)
    // a finished lookup leaves a result waiting
    `TLBPTU_ASSERT_NEXT(a_fire_result, i_clk, i_rst_n, w_fire, r_out_valid && r_state == ST_IDLE)
    // each fault takes exactly the next frame in order
    `TLBPTU_ASSERT_NEXT(a_fault_alloc, i_clk, i_rst_n, w_fire && w_fault, w_free_frame == $past(w_free_frame) + 1'b1)
endmodule

// ----- test/tlbptu_translation_checker.sv -----
// ------------------------------------------------------------------------
// tlbptu translation checker
// watches both channels, predicts each translation and compares results
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlbptu_translation_checker #(
    parameter int TLB_ENTRIES = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tlbptu_req_if i_req,
    tlbptu_rsp_if i_rsp,
    output int    o_fail_count,
    output int    o_pending
);
    import tlbptu_pkg::*;

    localparam int PRINT_LIMIT = 60;

    typedef struct packed {
        t_addr  physical_address;
        logic   tlb_hit;
        logic   page_fault;
        t_count hit_total;
        t_count fault_total;
        t_count translated_total;
    } t_translation;

    // predicted copy of the translation state
    t_page  tlb_tag   [TLB_ENTRIES];
    t_frame tlb_frame [TLB_ENTRIES];
    logic   tlb_valid [TLB_ENTRIES];
    int     insert_ptr;
    logic   map_valid [PAGE_COUNT];
    t_frame map_frame [PAGE_COUNT];
    t_free  free_frame;
    t_count hit_count;
    t_count fault_count;
    t_count translated_count;

    t_translation expected_translations[$];
    int           fail_total;

    initial begin
        fail_total   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_total < PRINT_LIMIT)
            $display("%0t ns: translation mismatch, %s: got %0h, want %0h",
                     $time, what, got, want);
        fail_total++;
    endtask

    function automatic t_translation translate_address(input t_addr la);
        t_translation res;
        t_page        page;
        t_frame       frame;
        int           slot;
        page = la[ADDR_BITS-1:OFFSET_BITS];
        slot = -1;
        res  = '0;
        // lowest matching valid entry wins
        for (int i = 0; i < TLB_ENTRIES; i++)
            if (slot < 0 && tlb_valid[i] && tlb_tag[i] == page)
                slot = i;
        if (slot >= 0) begin
            res.tlb_hit = 1'b1;
            frame = tlb_frame[slot];
            hit_count++;
        end else begin
            if (map_valid[page]) begin
                frame = map_frame[page];
            end else begin
                // demand paging: hand out the next frame in order
                res.page_fault = 1'b1;
                frame = t_frame'(free_frame);
                free_frame++;
                map_valid[page] = 1'b1;
                map_frame[page] = frame;
                fault_count++;
            end
            tlb_tag[insert_ptr]   = page;
            tlb_frame[insert_ptr] = frame;
            tlb_valid[insert_ptr] = 1'b1;
            insert_ptr = (insert_ptr == TLB_ENTRIES - 1) ? 0 : insert_ptr + 1;
        end
        translated_count++;
        res.physical_address = {frame, la[OFFSET_BITS-1:0]};
        res.hit_total        = hit_count;
        res.fault_total      = fault_count;
        res.translated_total = translated_count;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_translation want;
        if (!i_rst_n) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                tlb_tag[i]   = '0;
                tlb_frame[i] = '0;
                tlb_valid[i] = 1'b0;
            end
            for (int p = 0; p < PAGE_COUNT; p++) begin
                map_valid[p] = 1'b0;
                map_frame[p] = '0;
            end
            insert_ptr       = 0;
            free_frame       = '0;
            hit_count        = '0;
            fault_count      = '0;
            translated_count = '0;
            expected_translations.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                expected_translations.push_back(translate_address(i_req.virt_addr));
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_translations.size() == 0) begin
                    report_mismatch("item with nothing pending",
                                    32'(i_rsp.physical_address), '0);
                end else begin
                    want = expected_translations.pop_front();
                    if (i_rsp.physical_address !== want.physical_address)
                        report_mismatch("physical_address", 32'(i_rsp.physical_address),
                                        32'(want.physical_address));
                    if (i_rsp.tlb_hit !== want.tlb_hit)
                        report_mismatch("tlb_hit", 32'(i_rsp.tlb_hit), 32'(want.tlb_hit));
                    if (i_rsp.page_fault !== want.page_fault)
                        report_mismatch("page_fault", 32'(i_rsp.page_fault),
                                        32'(want.page_fault));
                    if (i_rsp.hit_total !== want.hit_total)
                        report_mismatch("hit_total", i_rsp.hit_total, want.hit_total);
                    if (i_rsp.fault_total !== want.fault_total)
                        report_mismatch("fault_total", i_rsp.fault_total, want.fault_total);
                    if (i_rsp.translated_total !== want.translated_total)
                        report_mismatch("translated_total", i_rsp.translated_total,
                                        want.translated_total);
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_translations.size();
    end

endmodule

// ----- test/tb_top.sv -----
// ------------------------------------------------------------------------
// tlb page table translator testbench
// directed and random address streams with random stalls on both sides,
// results checked by the translation checker
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tlbptu_pkg::*;

    localparam int TLB_ENTRIES  = 16;
    localparam int MAX_GAP      = 13;
    localparam int RANDOM_ITEMS = 1630;
    // long receiver hold-off, makes the block back up into its input
    localparam int HOLD_CYCLES  = 400;
    // cycles with no item moving on either channel before giving up
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 16;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;

    tlbptu_req_if req_ch ();
    tlbptu_rsp_if rsp_ch ();

    tlb_page_table_translator_unit #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tlbptu_translation_checker #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_translation_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // offer one address item, optionally after a random gap with valid low;
    // valid stays high between back-to-back items
    task automatic send_address(input t_addr addr, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.virt_addr <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // watchdog: ends the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random ready gaps per item, burst stretches with no gaps,
    // and two long hold-offs while the sender keeps offering
    initial begin : result_side
        int taken;
        int gap;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken == 150 || taken == 900) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = (((taken / 40) % 5) == 2) ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            taken++;
        end
    end

    // sender and verdict
    initial begin : address_side
        t_page hot_pages [24];
        int    hot_count;
        t_addr addr;
        hot_count = 1;
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.virt_addr <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes: first touches fault, repeats on a page hit
        send_address(16'h0000, 1'b0);
        send_address(16'h00ff, 1'b0);
        send_address(16'hffff, 1'b0);
        send_address(16'hff00, 1'b0);
        send_address(16'h8001, 1'b0);
        send_address(16'h7ffe, 1'b0);
        send_address(16'h5555, 1'b0);
        send_address(16'haaaa, 1'b0);
        // eleven more new pages: the fifo pointer wraps and evicts page 0
        for (int p = 1; p <= 11; p++)
            send_address({t_page'(p), t_offset'(p * 37)}, 1'b0);
        // evicted but mapped pages: tlb miss without a fault
        send_address(16'h0042, 1'b0);
        send_address(16'hff80, 1'b1);

        // random part: mostly a shifting working set around the tlb size,
        // so hits, misses, refills and faults all keep happening
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                hot_count = $urandom_range(4, 24);
                for (int k = 0; k < hot_count; k++)
                    hot_pages[k] = t_page'($urandom_range(0, PAGE_COUNT - 1));
            end
            if ($urandom_range(0, 9) < 6)
                addr = {hot_pages[$urandom_range(0, hot_count - 1)], t_offset'($urandom)};
            else
                addr = t_addr'($urandom);
            send_address(addr, ((n / 50) % 4) == 1);
        end
        req_ch.valid <= 1'b0;

        // let the checker see the last item before looking at the queue
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tlbptu_pkg.sv
hw/rtl/tlbptu_if.sv
hw/rtl/tlbptu_cell.sv
hw/rtl/tlbptu_tlb.sv
hw/rtl/tlbptu_page_map.sv
hw/rtl/tlb_page_table_translator_unit.sv
test/tlbptu_translation_checker.sv
test/tb_top.sv
